// ===== rtl/olie_pkg.sv =====
// Package for the ordered list core: sizes, codes and control/status bundles.
`default_nettype none
package olie_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;

    localparam logic [2:0] REQ_RESIZE = 3'd0;
    localparam logic [2:0] REQ_WRITE  = 3'd1;
    localparam logic [2:0] REQ_INSERT = 3'd2;
    localparam logic [2:0] REQ_ERASE  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PLACE,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_IDX,
        PTR_CNT,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [2:0] {
        RD_IDX,
        RD_IDX_P1,
        RD_CNT_M1,
        RD_PTR_P2,
        RD_PTR_M2
    } rd_sel_t;

    typedef enum logic [0:0] {
        WA_IDX,
        WA_PTR
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_WORD,
        WD_RD
    } wd_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_WANT,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic       load;
        ptr_op_t    ptr_op;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        wa_sel_t    wa_sel;
        wd_sel_t    wd_sel;
        cnt_op_t    cnt_op;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_use_rd;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       bad_rw;
        logic       ins_bad;
        logic       full;
        logic       clamp;
        logic       grow;
        logic       idx_last;
        logic       append;
        logic       fill_last;
        logic       erase_more;
        logic       insert_more;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/olie_dp.sv =====
// Datapath: request registers, entry memory, length, pointer and result registers.
`default_nettype none
module olie_dp
    import olie_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [2:0]               s_req_type,
    input  wire logic                     s_at_end,
    input  wire logic [6:0]               s_position,
    input  wire logic signed [DATA_W-1:0] s_data_value,
    input  wire logic [6:0]               s_new_length,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    output logic [1:0]                    m_status,
    output logic [6:0]                    m_length,
    output logic signed [DATA_W-1:0]      m_read_value
);

    logic [2:0]               kind_reg;
    logic                     last_reg;
    logic [6:0]               pos_reg;
    logic signed [DATA_W-1:0] word_reg;
    logic [6:0]               want_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        ptr_reg, ptr_next;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [1:0]               status_reg;
    logic [CNT_W-1:0]         length_reg;
    logic signed [DATA_W-1:0] value_reg;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]         idx;
    logic [CNT_W-1:0]         want_c;
    logic [CNT_W-1:0]         ptr_ext;
    logic [ADDR_W-1:0]        idx_a;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    assign ptr_ext = CNT_W'(ptr_reg);
    assign idx_a   = idx[ADDR_W-1:0];

    always_comb begin
        if (!last_reg) begin
            idx = pos_reg;
        end else if (kind_reg == REQ_INSERT) begin
            idx = count_reg;
        end else begin
            idx = count_reg - CNT_W'(1);
        end
        want_c = (want_reg > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : want_reg;
    end

    always_comb begin
        stat.kind        = kind_reg;
        stat.bad_rw      = (count_reg == '0) || (idx >= count_reg);
        stat.ins_bad     = idx > count_reg;
        stat.full        = count_reg >= CNT_W'(CAPACITY);
        stat.clamp       = want_reg > CNT_W'(CAPACITY);
        stat.grow        = count_reg < want_c;
        stat.idx_last    = idx == (count_reg - CNT_W'(1));
        stat.append      = idx == count_reg;
        stat.fill_last   = (ptr_ext + CNT_W'(1)) == want_c;
        stat.erase_more  = (ptr_ext + CNT_W'(2)) < count_reg;
        stat.insert_more = {1'b0, ptr_ext} > ({1'b0, idx} + (CNT_W + 1)'(1));
    end

    always_comb begin
        case (cmd.rd_sel)
            RD_IDX:    rd_addr = idx_a;
            RD_IDX_P1: rd_addr = idx_a + ADDR_W'(1);
            RD_CNT_M1: rd_addr = ADDR_W'(count_reg - CNT_W'(1));
            RD_PTR_P2: rd_addr = ptr_reg + ADDR_W'(2);
            RD_PTR_M2: rd_addr = ptr_reg - ADDR_W'(2);
            default:   rd_addr = idx_a;
        endcase
        wr_addr = (cmd.wa_sel == WA_PTR) ? ptr_reg : idx_a;
        case (cmd.wd_sel)
            WD_ZERO: wr_data = '0;
            WD_WORD: wr_data = word_reg;
            WD_RD:   wr_data = rd_data_reg;
            default: wr_data = '0;
        endcase
    end

    always_comb begin
        case (cmd.ptr_op)
            PTR_IDX: ptr_next = idx_a;
            PTR_CNT: ptr_next = count_reg[ADDR_W-1:0];
            PTR_INC: ptr_next = ptr_reg + ADDR_W'(1);
            PTR_DEC: ptr_next = ptr_reg - ADDR_W'(1);
            default: ptr_next = ptr_reg;
        endcase
        case (cmd.cnt_op)
            CNT_WANT: count_next = want_c;
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = count_reg - CNT_W'(1);
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.load) begin
            kind_reg <= s_req_type;
            last_reg <= s_at_end;
            pos_reg  <= s_position;
            word_reg <= s_data_value;
            want_reg <= s_new_length;
        end
        if (cmd.out_load) begin
            status_reg <= cmd.out_status;
            length_reg <= count_reg;
            value_reg  <= cmd.out_use_rd ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_status     = status_reg;
    assign m_length     = length_reg;
    assign m_read_value = value_reg;

endmodule
`default_nettype wire

// ===== rtl/olie_ctrl.sv =====
// Controller: request sequencing state machine and result handshake.
`default_nettype none
module olie_ctrl
    import olie_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] code_reg, code_next;
    logic       rd_ok_reg, rd_ok_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = state_reg == S_IDLE;
    assign m_valid  = out_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                case (stat.kind)
                    REQ_RESIZE: begin
                        if (stat.grow) begin
                            state_next = S_FILL;
                        end
                    end
                    REQ_ERASE: begin
                        if (!stat.bad_rw && !stat.idx_last) begin
                            state_next = S_SHIFT_DN;
                        end
                    end
                    REQ_INSERT: begin
                        if (!stat.ins_bad && !stat.full && !stat.append) begin
                            state_next = S_SHIFT_UP;
                        end
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_FILL: begin
                if (stat.fill_last) begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_DN: begin
                if (!stat.erase_more) begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_UP: begin
                if (!stat.insert_more) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        cmd.ptr_op     = PTR_HOLD;
        cmd.rd_sel     = RD_IDX;
        cmd.wa_sel     = WA_IDX;
        cmd.wd_sel     = WD_ZERO;
        cmd.cnt_op     = CNT_HOLD;
        cmd.out_status = code_reg;
        cmd.out_use_rd = rd_ok_reg;
        code_next      = code_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                cmd.load = s_valid;
            end
            S_DECODE: begin
                code_next  = STAT_DONE;
                rd_ok_next = 1'b0;
                case (stat.kind)
                    REQ_RESIZE: begin
                        code_next  = stat.clamp ? STAT_FULL : STAT_DONE;
                        cmd.cnt_op = CNT_WANT;
                        cmd.ptr_op = PTR_CNT;
                    end
                    REQ_WRITE: begin
                        if (stat.bad_rw) begin
                            code_next = STAT_IGNORED;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_IDX;
                            cmd.wd_sel = WD_WORD;
                        end
                    end
                    REQ_READ: begin
                        if (stat.bad_rw) begin
                            code_next = STAT_IGNORED;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_IDX;
                            rd_ok_next = 1'b1;
                        end
                    end
                    REQ_ERASE: begin
                        if (stat.bad_rw) begin
                            code_next = STAT_IGNORED;
                        end else if (stat.idx_last) begin
                            cmd.cnt_op = CNT_DEC;
                        end else begin
                            cmd.ptr_op = PTR_IDX;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_IDX_P1;
                        end
                    end
                    REQ_INSERT: begin
                        if (stat.ins_bad) begin
                            code_next = STAT_IGNORED;
                        end else if (stat.full) begin
                            code_next = STAT_FULL;
                        end else if (stat.append) begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_IDX;
                            cmd.wd_sel = WD_WORD;
                            cmd.cnt_op = CNT_INC;
                        end else begin
                            cmd.ptr_op = PTR_CNT;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_CNT_M1;
                        end
                    end
                    default: code_next = STAT_IGNORED;
                endcase
            end
            S_FILL: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_ZERO;
                cmd.ptr_op = PTR_INC;
            end
            S_SHIFT_DN: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_RD;
                if (stat.erase_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_P2;
                    cmd.ptr_op = PTR_INC;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            S_SHIFT_UP: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_RD;
                if (stat.insert_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_M2;
                    cmd.ptr_op = PTR_DEC;
                end
            end
            S_PLACE: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_IDX;
                cmd.wd_sel = WD_WORD;
                cmd.cnt_op = CNT_INC;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            code_reg      <= STAT_DONE;
            rd_ok_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            code_reg      <= code_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ordered_list_insert_erase_core.sv =====
// Ordered list core: up to 64 signed words with resize, write, insert, erase and read.
//
// Usage: one request item on the s_ channel (req_type, at_end, position, data_value,
// new_length) gives exactly one result item on the m_ channel (status, length,
// read_value). Both channels are valid/ready; an item moves when both are high.
// One request is worked at a time: s_ready is high only while the sequencer is idle.
// Write, read, erase of the last entry, append, shrink and every ignored or refused
// request pass from idle through the decode state straight to the finish state, which
// loads the result register. Insert and erase in the middle move one entry per cycle
// through the entry memory (one read and one write port) in the shift states; insert
// then places the new word in the place state. Resize growth zero-fills one entry per
// cycle in the fill state.
// The result sits in an output register; a new request is accepted while it
// waits, but that request's result holds off until m_ready takes the old one.
// Reset (aresetn low, synchronous) empties the list and drops any pending result;
// entry memory contents are not cleared and need no clearing pass.
`default_nettype none
module ordered_list_insert_erase_core
    import olie_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [2:0]               s_req_type,
    input  wire logic                     s_at_end,
    input  wire logic [6:0]               s_position,
    input  wire logic signed [DATA_W-1:0] s_data_value,
    input  wire logic [6:0]               s_new_length,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_status,
    output logic [6:0]                    m_length,
    output logic signed [DATA_W-1:0]      m_read_value
);

    cmd_t  cmd;
    stat_t stat;

    olie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    olie_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_req_type   (s_req_type),
        .s_at_end     (s_at_end),
        .s_position   (s_position),
        .s_data_value (s_data_value),
        .s_new_length (s_new_length),
        .cmd          (cmd),
        .stat         (stat),
        .m_status     (m_status),
        .m_length     (m_length),
        .m_read_value (m_read_value)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length <= 7'(CAPACITY))
        else $error("length beyond capacity");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_DONE || m_status == STAT_IGNORED ||
                     m_status == STAT_FULL))
        else $error("bad status code");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_DONE |-> m_read_value == '0)
        else $error("read value on a failed request");

endmodule
`default_nettype wire
